/* design/srgb_pkg.sv */
// ----------------------------------------------------------------------------
// srgb_pkg: shared types and constants of the serial RGB LED transmitter
// Request and status codes, frame phases, register map and store sizing.
// ----------------------------------------------------------------------------
package srgb_pkg;

  // Pixel store sizing
  localparam int MAX_LEDS     = 256;
  localparam int LED_AW       = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int LEN_W        = $clog2(MAX_LEDS + 1);
  localparam int PIXEL_W      = 24;
  localparam int BITS_PER_LED = 24;

  // Configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // Register reset values
  localparam logic [7:0]  RST_BIT0_HIGH = 8'd3;
  localparam logic [7:0]  RST_BIT0_LOW  = 8'd9;
  localparam logic [7:0]  RST_BIT1_HIGH = 8'd6;
  localparam logic [7:0]  RST_BIT1_LOW  = 8'd6;
  localparam logic [15:0] RST_LATCH     = 16'd10000;
  localparam logic [8:0]  RST_CHAIN_LEN = 9'd1;

  // Register index (byte address / 4)
  typedef enum logic [2:0] {
    REG_BIT0_HIGH = 3'd0,
    REG_BIT0_LOW  = 3'd1,
    REG_BIT1_HIGH = 3'd2,
    REG_BIT1_LOW  = 3'd3,
    REG_LATCH     = 3'd4,
    REG_CHAIN_LEN = 3'd5,
    REG_INVERT    = 3'd6
  } reg_idx_t;

  // Request codes
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_FILL  = 2'd1,
    REQ_SHOW  = 2'd2,
    REQ_TICK  = 2'd3
  } req_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_BUSY  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Frame phase, one-hot
  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_DATA  = 3'b010,
    PH_LATCH = 3'b100
  } phase_t;

  // Effective configuration as seen by the datapath
  typedef struct packed {
    logic [7:0]       bit0_high;
    logic [7:0]       bit0_low;
    logic [7:0]       bit1_high;
    logic [7:0]       bit1_low;
    logic [15:0]      latch;
    logic [LEN_W-1:0] eff_len;
    logic             invert;
  } cfg_t;

  // Frame engine status toward the request controller
  typedef struct packed {
    logic busy;
    logic level;
    logic loading;
  } frame_stat_t;

endpackage

/* design/srgb_ram.sv */
// ----------------------------------------------------------------------------
// srgb_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module srgb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/srgb_cfg.sv */
// ----------------------------------------------------------------------------
// srgb_cfg: configuration registers
// APB-style register bank; derives the effective timing and chain length.
// ----------------------------------------------------------------------------
module srgb_cfg
  import srgb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  localparam int CL_W = (LEN_W > 9) ? LEN_W : 9;

  logic [7:0]  bit0_high;
  logic [7:0]  bit0_low;
  logic [7:0]  bit1_high;
  logic [7:0]  bit1_low;
  logic [15:0] latch;
  logic [8:0]  chain_len;
  logic        invert;

  logic        wr_en;
  reg_idx_t    idx;
  logic [CL_W-1:0] cl_ext;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bit0_high <= RST_BIT0_HIGH;
      bit0_low  <= RST_BIT0_LOW;
      bit1_high <= RST_BIT1_HIGH;
      bit1_low  <= RST_BIT1_LOW;
      latch     <= RST_LATCH;
      chain_len <= RST_CHAIN_LEN;
      invert    <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_BIT0_HIGH: bit0_high <= pwdata[7:0];
        REG_BIT0_LOW:  bit0_low  <= pwdata[7:0];
        REG_BIT1_HIGH: bit1_high <= pwdata[7:0];
        REG_BIT1_LOW:  bit1_low  <= pwdata[7:0];
        REG_LATCH:     latch     <= pwdata[15:0];
        REG_CHAIN_LEN: chain_len <= pwdata[8:0];
        REG_INVERT:    invert    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back raw register values
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_BIT0_HIGH: prdata = CFG_DW'(bit0_high);
      REG_BIT0_LOW:  prdata = CFG_DW'(bit0_low);
      REG_BIT1_HIGH: prdata = CFG_DW'(bit1_high);
      REG_BIT1_LOW:  prdata = CFG_DW'(bit1_low);
      REG_LATCH:     prdata = CFG_DW'(latch);
      REG_CHAIN_LEN: prdata = CFG_DW'(chain_len);
      REG_INVERT:    prdata = CFG_DW'(invert);
      default:       prdata = '0;
    endcase
  end

  // Zero durations count as one tick; clamp chain length to the store
  assign cl_ext = CL_W'(chain_len);

  always_comb begin
    cfg.bit0_high = (bit0_high == 8'd0) ? 8'd1 : bit0_high;
    cfg.bit0_low  = (bit0_low  == 8'd0) ? 8'd1 : bit0_low;
    cfg.bit1_high = (bit1_high == 8'd0) ? 8'd1 : bit1_high;
    cfg.bit1_low  = (bit1_low  == 8'd0) ? 8'd1 : bit1_low;
    cfg.latch     = (latch     == 16'd0) ? 16'd1 : latch;
    cfg.invert    = invert;
    if (cl_ext == '0) begin
      cfg.eff_len = LEN_W'(1);
    end else if (cl_ext > CL_W'(MAX_LEDS)) begin
      cfg.eff_len = LEN_W'(MAX_LEDS);
    end else begin
      cfg.eff_len = LEN_W'(cl_ext);
    end
  end

endmodule

/* design/srgb_frame.sv */
// ----------------------------------------------------------------------------
// srgb_frame: frame sequencer and bit shifter
// Shifts each pixel word out one bit per line bit, times the high and low
// parts with the tick counter, then runs the latch period.
// ----------------------------------------------------------------------------
module srgb_frame
  import srgb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               show_go,
  input  logic               tick_go,
  input  logic [PIXEL_W-1:0] rd_data,
  output logic               rd_en,
  output logic [LED_AW-1:0]  rd_addr,
  output frame_stat_t        stat
);

  phase_t             phase, phase_next;
  logic [LEN_W-1:0]   led, led_next;
  logic [4:0]         bitp, bitp_next;
  logic               lphase, lphase_next;
  logic [15:0]        tcnt, tcnt_next;
  logic [PIXEL_W-1:0] sword, sword_next;
  logic               loading, loading_next;

  logic [7:0]         dur;
  logic [15:0]        cnt_inc;
  logic [LEN_W-1:0]   led_inc;

  assign cnt_inc = tcnt + 16'd1;
  assign led_inc = led + LEN_W'(1);

  // Pick the duration of the current half bit from the bit on top
  always_comb begin
    if (!lphase) begin
      dur = sword[PIXEL_W-1] ? cfg.bit1_high : cfg.bit0_high;
    end else begin
      dur = sword[PIXEL_W-1] ? cfg.bit1_low : cfg.bit0_low;
    end
  end

  // Advance the frame on show and tick items
  always_comb begin
    phase_next   = phase;
    led_next     = led;
    bitp_next    = bitp;
    lphase_next  = lphase;
    tcnt_next    = tcnt;
    sword_next   = sword;
    loading_next = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = '0;

    // Load the fetched pixel word
    if (loading) begin
      sword_next = rd_data;
    end

    if (show_go) begin
      phase_next   = PH_DATA;
      led_next     = '0;
      bitp_next    = '0;
      lphase_next  = 1'b0;
      tcnt_next    = '0;
      rd_en        = 1'b1;
      rd_addr      = '0;
      loading_next = 1'b1;
    end else if (tick_go) begin
      unique case (phase)
        PH_DATA: begin
          if (cnt_inc < {8'd0, dur}) begin
            tcnt_next = cnt_inc;
          end else begin
            tcnt_next = '0;
            if (!lphase) begin
              lphase_next = 1'b1;
            end else begin
              lphase_next = 1'b0;
              sword_next  = {sword[PIXEL_W-2:0], 1'b0};
              if (bitp == 5'(BITS_PER_LED - 1)) begin
                bitp_next = '0;
                if (led_inc >= cfg.eff_len) begin
                  phase_next = PH_LATCH;
                  led_next   = '0;
                end else begin
                  led_next     = led_inc;
                  rd_en        = 1'b1;
                  rd_addr      = LED_AW'(led_inc);
                  loading_next = 1'b1;
                end
              end else begin
                bitp_next = bitp + 5'd1;
              end
            end
          end
        end
        PH_LATCH: begin
          if (cnt_inc >= cfg.latch) begin
            tcnt_next  = '0;
            phase_next = PH_IDLE;
          end else begin
            tcnt_next = cnt_inc;
          end
        end
        PH_IDLE: ;
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      led     <= '0;
      bitp    <= '0;
      lphase  <= 1'b0;
      tcnt    <= '0;
      sword   <= '0;
      loading <= 1'b0;
    end else begin
      phase   <= phase_next;
      led     <= led_next;
      bitp    <= bitp_next;
      lphase  <= lphase_next;
      tcnt    <= tcnt_next;
      sword   <= sword_next;
      loading <= loading_next;
    end
  end

  assign stat.busy    = (phase != PH_IDLE);
  assign stat.level   = (phase == PH_DATA) && !lphase;
  assign stat.loading = loading;

endmodule

/* design/serial_rgb_led_transmitter_core.sv */
// ----------------------------------------------------------------------------
// serial_rgb_led_transmitter_core: single-wire RGB LED chain driver
// Pixel store, fill sweep, request decode and result register.
// ----------------------------------------------------------------------------
// Usage:
//   Present an item on req_type/pixel_index/red/green/blue with start high;
//   it is taken at the edge where start is high and busy is low. Each item
//   gives one result (line_level, busy_res, status) on the cycle after it is
//   taken, marked by done for exactly one cycle; the receiver cannot stall.
//   Write pixel, refused and most tick items leave busy low. A show item,
//   and a tick that ends an LED other than the last, hold busy high in the
//   cycle after it is taken while the next pixel word is read from the store
//   (one read port, registered read). A fill item returns its result at once
//   and then holds busy while the sweep writes one entry per cycle.
//   At reset a clearing pass writes zero to all MAX_LEDS (256) store entries,
//   one per cycle; busy stays high throughout. Registers reset to their
//   defaults and may be written over the APB port during that pass.
//   Line timing is given in tick items: one tick item is one 100 ns tick.
// ----------------------------------------------------------------------------
module serial_rgb_led_transmitter_core
  import srgb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // item channel
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        req_type,
  input  logic [7:0]        pixel_index,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  // result channel
  output logic              done,
  output logic              line_level,
  output logic              busy_res,
  output logic [1:0]        status,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int IDX_W = (LEN_W > 8) ? LEN_W : 8;

  cfg_t               cfg;
  frame_stat_t        fstat;
  logic               accept;
  req_t               req;
  logic [PIXEL_W-1:0] color;

  logic               show_go, tick_go, wr_pixel, fill_go;
  logic               res_level;
  logic               res_busy;
  status_t            res_status;

  logic               sweep_active;
  logic [LED_AW-1:0]  sweep_addr;
  logic [LED_AW-1:0]  sweep_last;
  logic [PIXEL_W-1:0] sweep_data;

  logic               ram_we;
  logic [LED_AW-1:0]  ram_waddr;
  logic [PIXEL_W-1:0] ram_wdata;
  logic               ram_re;
  logic [LED_AW-1:0]  ram_raddr;
  logic [PIXEL_W-1:0] ram_rdata;

  srgb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  srgb_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .show_go (show_go),
    .tick_go (tick_go),
    .rd_data (ram_rdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .stat    (fstat)
  );

  srgb_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (MAX_LEDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy   = sweep_active | fstat.loading;
  assign accept = start & ~busy;
  assign req    = req_t'(req_type);
  assign color  = {green, red, blue};

  // Decode the item and form its result
  always_comb begin
    show_go    = 1'b0;
    tick_go    = 1'b0;
    wr_pixel   = 1'b0;
    fill_go    = 1'b0;
    res_level  = fstat.level;
    res_busy   = fstat.busy;
    res_status = ST_DONE;
    if (accept) begin
      if (req == REQ_TICK) begin
        tick_go = 1'b1;
      end else if (fstat.busy) begin
        res_status = ST_BUSY;
      end else begin
        unique case (req)
          REQ_WRITE: begin
            if (IDX_W'(pixel_index) >= IDX_W'(cfg.eff_len)) begin
              res_status = ST_RANGE;
            end else begin
              wr_pixel = 1'b1;
            end
          end
          REQ_FILL: fill_go = 1'b1;
          REQ_SHOW: begin
            show_go   = 1'b1;
            res_level = 1'b1;
            res_busy  = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // Register the result and flag it with done
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_level <= res_level ^ cfg.invert;
      busy_res   <= res_busy;
      status     <= res_status;
    end
  end

  // Sweep the store: clear after reset, or fill the chain with one color
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_active <= 1'b1;
      sweep_addr   <= '0;
      sweep_last   <= LED_AW'(MAX_LEDS - 1);
      sweep_data   <= '0;
    end else if (sweep_active) begin
      if (sweep_addr == sweep_last) begin
        sweep_active <= 1'b0;
      end else begin
        sweep_addr <= sweep_addr + LED_AW'(1);
      end
    end else if (fill_go) begin
      sweep_active <= 1'b1;
      sweep_addr   <= '0;
      sweep_last   <= LED_AW'(cfg.eff_len - LEN_W'(1));
      sweep_data   <= color;
    end
  end

  // Store write port
  assign ram_we    = sweep_active | wr_pixel;
  assign ram_waddr = sweep_active ? sweep_addr : LED_AW'(pixel_index);
  assign ram_wdata = sweep_active ? sweep_data : color;

endmodule
